[design/rrd_pkg.sv]
// ----------------------------------------------------------------------------
// rrd_pkg
// Widths, limits and shared types of the radial RMS deviation block.
// ----------------------------------------------------------------------------
package rrd_pkg;

  localparam int MAX_POINTS    = 4096;
  localparam int COORD_BITS    = 16;
  localparam int RMS_FRAC_BITS = 8;

  localparam int COUNT_W  = $clog2(MAX_POINTS + 1);
  localparam int SUM_W    = COORD_BITS + $clog2(MAX_POINTS) ;
  localparam int SQ_W     = 2 * COORD_BITS + 1 + $clog2(MAX_POINTS);
  localparam int RMS_W    = 24;

  // back end arithmetic
  localparam int MUL_W      = 28;
  localparam int TOTAL_W    = 2 * MUL_W;
  localparam int SPLIT      = 28;
  localparam int SCALE_BITS = 2 * RMS_FRAC_BITS;
  localparam int DIV_W      = TOTAL_W + SCALE_BITS;
  localparam int DEN_W      = 2 * COUNT_W - 1;
  localparam int QUOT_W     = 2 * RMS_W;
  localparam int SQRT_STEPS = QUOT_W / 2;
  localparam int STEP_W     = $clog2(DIV_W + 1);

  typedef struct packed {
    logic [COUNT_W-1:0]      n;
    logic signed [SUM_W-1:0] sx;
    logic signed [SUM_W-1:0] sy;
    logic [SQ_W-1:0]         sq;
    logic                    ovf;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

[design/rrd_front.sv]
// ----------------------------------------------------------------------------
// rrd_front
// Takes one point per cycle, when not stalled, into running sums; on the last
// point of a set it hands the finished sums to the job queue and clears them.
// ----------------------------------------------------------------------------
module rrd_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [rrd_pkg::COORD_BITS-1:0] point_x,
  input  logic signed [rrd_pkg::COORD_BITS-1:0] point_y,
  input  logic                                 last_point,
  input  rrd_pkg::qstat_t                      qstat,
  output logic                                 push,
  output rrd_pkg::job_t                        job
);
  import rrd_pkg::*;

  logic [COUNT_W-1:0]      count;
  logic signed [SUM_W-1:0] sx;
  logic signed [SUM_W-1:0] sy;
  logic [SQ_W-1:0]         sq;
  logic                    ovf;

  logic [COUNT_W-1:0]      count_next;
  logic signed [SUM_W-1:0] sx_next;
  logic signed [SUM_W-1:0] sy_next;
  logic [SQ_W-1:0]         sq_next;
  logic                    ovf_next;
  logic signed [2*COORD_BITS-1:0] xx;
  logic signed [2*COORD_BITS-1:0] yy;
  logic                    room;
  logic                    accept;

  // only a closing word needs a queue slot
  assign in_stall = qstat.full & last_point;
  assign accept   = in_valid & ~in_stall;
  assign push     = accept & last_point;

  assign xx   = point_x * point_x;
  assign yy   = point_y * point_y;
  assign room = count < COUNT_W'(MAX_POINTS);

  always_comb begin
    count_next = count;
    sx_next    = sx;
    sy_next    = sy;
    sq_next    = sq;
    ovf_next   = ovf;
    if (room) begin
      count_next = count + COUNT_W'(1);
      sx_next    = sx + SUM_W'(point_x);
      sy_next    = sy + SUM_W'(point_y);
      sq_next    = sq + SQ_W'(unsigned'(xx)) + SQ_W'(unsigned'(yy));
    end else begin
      ovf_next = 1'b1;
    end
  end

  always_comb begin
    job.n   = count_next;
    job.sx  = sx_next;
    job.sy  = sy_next;
    job.sq  = sq_next;
    job.ovf = ovf_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      sx    <= '0;
      sy    <= '0;
      sq    <= '0;
      ovf   <= 1'b0;
    end else if (accept) begin
      if (last_point) begin
        count <= '0;
        sx    <= '0;
        sy    <= '0;
        sq    <= '0;
        ovf   <= 1'b0;
      end else begin
        count <= count_next;
        sx    <= sx_next;
        sy    <= sy_next;
        sq    <= sq_next;
        ovf   <= ovf_next;
      end
    end
  end

endmodule

[design/rrd_job_queue.sv]
// ----------------------------------------------------------------------------
// rrd_job_queue
// Two-entry queue of finished sets between the accumulator and the back end.
// ----------------------------------------------------------------------------
module rrd_job_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  rrd_pkg::job_t   push_job,
  input  logic            pop,
  output rrd_pkg::job_t   head,
  output rrd_pkg::qstat_t qstat
);
  import rrd_pkg::*;

  job_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       do_push;
  logic       do_pop;

  assign do_push     = push & ~qstat.full;
  assign do_pop      = pop & ~qstat.empty;
  assign qstat.full  = fill == 2'd2;
  assign qstat.empty = fill == 2'd0;
  assign head        = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop)  rd_ptr <= ~rd_ptr;
      case ({do_push, do_pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

[design/rrd_back.sv]
// ----------------------------------------------------------------------------
// rrd_back
// Per set: total = n*sumsq - sx^2 - sy^2 and n^2 on one shared multiplier,
// then restoring division of total*4^frac by n^2, then a bit-pair square root.
// ----------------------------------------------------------------------------
module rrd_back (
  input  logic                        clk,
  input  logic                        rst,
  input  rrd_pkg::job_t               head,
  input  rrd_pkg::qstat_t             qstat,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [rrd_pkg::RMS_W-1:0]   rms_value,
  output logic [rrd_pkg::COUNT_W-1:0] points_used,
  output logic                        points_dropped
);
  import rrd_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_SQRT = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  localparam int MUL_STEPS = 5;

  logic [2:0]          state;
  logic [STEP_W-1:0]   step;

  logic [COUNT_W-1:0]  n_r;
  logic [MUL_W-1:0]    mx;
  logic [MUL_W-1:0]    my;
  logic [SQ_W-1:0]     sq_r;
  logic                ovf_r;

  logic [MUL_W-1:0]    mul_a;
  logic [MUL_W-1:0]    mul_b;
  logic [TOTAL_W-1:0]  prod;
  logic [TOTAL_W-1:0]  acc;
  logic [DEN_W-1:0]    den;

  logic [DIV_W-1:0]    dsr;
  logic [DEN_W-1:0]    rem;
  logic [DEN_W:0]      r2;
  logic                qbit;
  logic [QUOT_W-1:0]   quot;
  logic                sat;

  logic [QUOT_W-1:0]   s_res;
  logic [QUOT_W-1:0]   s_bit;
  logic [QUOT_W-1:0]   s_try;

  logic                out_free;

  assign pop      = (state == ST_IDLE) & ~qstat.empty;
  assign out_free = ~out_valid | ~out_stall;

  always_comb begin
    case (step)
      STEP_W'(0): begin mul_a = MUL_W'(n_r); mul_b = MUL_W'(sq_r[SPLIT-1:0]);     end
      STEP_W'(1): begin mul_a = MUL_W'(n_r); mul_b = MUL_W'(sq_r[SQ_W-1:SPLIT]);  end
      STEP_W'(2): begin mul_a = mx;          mul_b = mx;                          end
      STEP_W'(3): begin mul_a = my;          mul_b = my;                          end
      default:    begin mul_a = MUL_W'(n_r); mul_b = MUL_W'(n_r);                 end
    endcase
  end

  assign r2    = {rem, dsr[DIV_W-1]};
  assign qbit  = r2 >= {1'b0, den};
  assign s_try = s_res + s_bit;

  always_ff @(posedge clk) begin
    if (pop) begin
      n_r   <= head.n;
      mx    <= head.sx[SUM_W-1] ? MUL_W'(unsigned'(-head.sx)) : MUL_W'(unsigned'(head.sx));
      my    <= head.sy[SUM_W-1] ? MUL_W'(unsigned'(-head.sy)) : MUL_W'(unsigned'(head.sy));
      sq_r  <= head.sq;
      ovf_r <= head.ovf;
    end
    case (state)
      ST_MUL: begin
        prod <= mul_a * mul_b;
        // product of the previous step is registered in prod and folded into acc at the next step
        case (step)
          STEP_W'(1): acc <= prod;
          STEP_W'(2): acc <= acc + (prod << SPLIT);
          STEP_W'(3): acc <= acc - prod;
          STEP_W'(4): acc <= acc - prod;
          default:    acc <= acc;
        endcase
        if (step == STEP_W'(MUL_STEPS)) begin
          den  <= prod[DEN_W-1:0];
          dsr  <= {acc, SCALE_BITS'(0)};
          rem  <= '0;
          quot <= '0;
          sat  <= 1'b0;
        end
      end
      ST_DIV: begin
        dsr  <= dsr << 1;
        rem  <= qbit ? DEN_W'(r2 - {1'b0, den}) : r2[DEN_W-1:0];
        quot <= {quot[QUOT_W-2:0], qbit};
        sat  <= sat | quot[QUOT_W-1];
        if (step == STEP_W'(DIV_W - 1)) begin
          s_res <= '0;
          s_bit <= QUOT_W'(1) << (QUOT_W - 2);
        end
      end
      ST_SQRT: begin
        // quot now holds the shrinking radicand
        if (quot >= s_try) begin
          quot  <= quot - s_try;
          s_res <= (s_res >> 1) + s_bit;
        end else begin
          s_res <= s_res >> 1;
        end
        s_bit <= s_bit >> 2;
      end
      ST_DONE: begin
        if (out_free) begin
          rms_value      <= sat ? '1 : s_res[RMS_W-1:0];
          points_used    <= n_r;
          points_dropped <= ovf_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      if ((state == ST_DONE) && out_free) begin
        out_valid <= 1'b1;
      end else if (~out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          step <= '0;
          if (pop) state <= ST_MUL;
        end
        ST_MUL: begin
          if (step == STEP_W'(MUL_STEPS)) begin
            step  <= '0;
            state <= ST_DIV;
          end else begin
            step <= step + STEP_W'(1);
          end
        end
        ST_DIV: begin
          if (step == STEP_W'(DIV_W - 1)) begin
            step  <= '0;
            state <= ST_SQRT;
          end else begin
            step <= step + STEP_W'(1);
          end
        end
        ST_SQRT: begin
          if (step == STEP_W'(SQRT_STEPS - 1)) begin
            step  <= '0;
            state <= ST_DONE;
          end else begin
            step <= step + STEP_W'(1);
          end
        end
        ST_DONE: begin
          if (out_free) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

[design/radial_rms_deviation.sv]
// ----------------------------------------------------------------------------
// radial_rms_deviation
// RMS distance of a set of 2D points from their centroid, 8 fraction bits.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): one point word per cycle unless
// stalled, point_x, point_y signed, last_point closes the set. Points
// past capacity are not summed and set points_dropped for that set.
// Output channel (out_valid / out_stall): one result word per set with
// rms_value, points_used and points_dropped, held in an output register.
// Points are summed at one per cycle while in_stall is low. A closed set
// goes to a two-entry queue; for each set the back end takes it from the
// queue, runs the shared multiplier, the bit-serial divider and the square
// root, and loads the output register. It takes a new set from the queue
// only once it is through with the last one. Sets that arrive faster than
// the back end finishes them run at its pace: in_stall rises only on a last
// point while the queue is full. A stalled output holds its word and stops
// the back end, which then fills the queue and stalls the next last point.
// Reset (rst, synchronous) clears the sums, the queue and out_valid.
// ----------------------------------------------------------------------------
module radial_rms_deviation (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [rrd_pkg::COORD_BITS-1:0] point_x,
  input  logic signed [rrd_pkg::COORD_BITS-1:0] point_y,
  input  logic                                 last_point,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [rrd_pkg::RMS_W-1:0]            rms_value,
  output logic [rrd_pkg::COUNT_W-1:0]          points_used,
  output logic                                 points_dropped
);
  import rrd_pkg::*;

  logic   push;
  job_t   push_job;
  job_t   head;
  logic   pop;
  qstat_t qstat;

  rrd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .point_x    (point_x),
    .point_y    (point_y),
    .last_point (last_point),
    .qstat      (qstat),
    .push       (push),
    .job        (push_job)
  );

  rrd_job_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .qstat    (qstat)
  );

  rrd_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head           (head),
    .qstat          (qstat),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .rms_value      (rms_value),
    .points_used    (points_used),
    .points_dropped (points_dropped)
  );

  a_queue_flags: assert property (@(posedge clk) disable iff (rst)
    !(qstat.full && qstat.empty))
    else $error("queue full and empty at once");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !qstat.empty)
    else $error("back end popped an empty queue");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (qstat.full && last_point))
    else $error("input stalled without a full queue");

  a_push_lands: assert property (@(posedge clk) disable iff (rst)
    push |=> !qstat.empty)
    else $error("pushed set missing from queue");

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (points_used != '0))
    else $error("result with no points");

endmodule

[bench/rrd_checker.sv]
// ----------------------------------------------------------------------------
// rrd_checker
// Watches both channels of radial_rms_deviation, predicts the result word of
// each closed point set from exact running sums and compares it, field by
// field, with the word that the block delivers.
// ----------------------------------------------------------------------------
module rrd_checker (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  input  logic                                  in_stall,
  input  logic signed [rrd_pkg::COORD_BITS-1:0] point_x,
  input  logic signed [rrd_pkg::COORD_BITS-1:0] point_y,
  input  logic                                  last_point,
  input  logic                                  out_valid,
  input  logic                                  out_stall,
  input  logic [rrd_pkg::RMS_W-1:0]             rms_value,
  input  logic [rrd_pkg::COUNT_W-1:0]           points_used,
  input  logic                                  points_dropped,
  output int                                    errors,
  output int                                    results_waiting
);
  import rrd_pkg::*;

  typedef struct {
    logic [RMS_W-1:0]   rms;
    logic [COUNT_W-1:0] used;
    logic               dropped;
  } rrd_result_t;

  rrd_result_t       rms_results[$];
  rrd_result_t       want;
  rrd_result_t       next_result;
  int unsigned       set_count;
  longint            set_sum_x;
  longint            set_sum_y;
  longint unsigned   set_sum_sq;
  bit                set_overflow;
  longint            px;
  longint            py;

  // n^2 * variance, scaled by 4^RMS_FRAC_BITS, divided by n^2, then floor sqrt
  function automatic logic [RMS_W-1:0] centroid_rms(longint unsigned n, longint sx,
                                                     longint sy, longint unsigned sq);
    longint unsigned ax, ay, total, den, quo, rem, root, trial;
    int i, b;
    ax = (sx < 0) ? -sx : sx;
    ay = (sy < 0) ? -sy : sy;
    total = n * sq - ax * ax - ay * ay;
    den = n * n;
    if (den == 0) return '0;
    quo = total / den;
    rem = total % den;
    for (i = 0; i < 2 * RMS_FRAC_BITS; i++) begin
      if (quo[63:62] != 2'b00) return '1;
      quo = quo << 1;
      rem = rem << 1;
      if (rem >= den) begin
        rem = rem - den;
        quo[0] = 1'b1;
      end
    end
    root = 0;
    for (b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= quo) root = trial;
    end
    return (root > 64'hFF_FFFF) ? '1 : root[RMS_W-1:0];
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      rms_results.delete();
      set_count = 0;
      set_sum_x = 0;
      set_sum_y = 0;
      set_sum_sq = 0;
      set_overflow = 0;
    end else begin
      // result side first: a word closed in this cycle cannot leave yet
      if (out_valid && !out_stall) begin
        if (rms_results.size() == 0) begin
          $error("unexpected result word: rms_value %0d points_used %0d points_dropped %0d",
                 rms_value, points_used, points_dropped);
          errors++;
        end else begin
          want = rms_results.pop_front();
          if (rms_value !== want.rms) begin
            $error("rms_value: expected %0d, got %0d", want.rms, rms_value);
            errors++;
          end
          if (points_used !== want.used) begin
            $error("points_used: expected %0d, got %0d", want.used, points_used);
            errors++;
          end
          if (points_dropped !== want.dropped) begin
            $error("points_dropped: expected %0d, got %0d", want.dropped, points_dropped);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (set_count < MAX_POINTS) begin
          px = longint'(point_x);
          py = longint'(point_y);
          set_sum_x += px;
          set_sum_y += py;
          set_sum_sq += px * px + py * py;
          set_count++;
        end else begin
          set_overflow = 1'b1;
        end
        if (last_point) begin
          next_result.rms = centroid_rms(64'(set_count), set_sum_x, set_sum_y, set_sum_sq);
          next_result.used = COUNT_W'(set_count);
          next_result.dropped = set_overflow;
          rms_results.insert(rms_results.size(), next_result);
          set_count = 0;
          set_sum_x = 0;
          set_sum_y = 0;
          set_sum_sq = 0;
          set_overflow = 0;
        end
      end
    end
    results_waiting <= rms_results.size();
  end

endmodule

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Feeds radial_rms_deviation with point sets: a few directed sets at the
// coordinate extremes and of known deviation, random sets of varied shape
// and a long output hold-off that backs up the block. The sender idles in
// bursts, the receiver stalls on changing patterns; rrd_checker predicts
// and compares every result word.
// ----------------------------------------------------------------------------
module testbench;
  import rrd_pkg::*;

  localparam int ITEM_TARGET    = 1150;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 800;
  localparam int DRAIN_CYCLES   = 250;

  localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
  localparam logic signed [COORD_BITS-1:0] COORD_MAX = ~COORD_MIN;

  typedef enum {COORD_ANY, COORD_EXTREME, COORD_CLUSTER} coord_mode_t;
  typedef enum {STALL_NONE, STALL_HALF, STALL_MOST, STALL_PATTERN} stall_mode_t;

  logic                         clk;
  logic                         rst;
  logic                         in_valid;
  logic                         in_stall;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic                         last_point;
  logic                         out_valid;
  logic                         out_stall;
  logic [RMS_W-1:0]             rms_value;
  logic [COUNT_W-1:0]           points_used;
  logic                         points_dropped;

  int errors;
  int results_waiting;
  int idle_cycles;
  int burst_left;
  int points_sent;
  bit hold_req;
  bit quiet_sender;
  bit pressure_done;

  radial_rms_deviation i_dut (.*);
  rrd_checker i_checker (.*);

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // nothing accepted on either side for too long: the block has hung
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("testbench failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver: changing stall patterns, plus one long hold-off on request
  initial begin
    stall_mode_t mode;
    int phase_left;
    bit [7:0] mask;
    bit held;
    out_stall = 1'b0;
    mode = STALL_NONE;
    phase_left = 0;
    mask = '0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (phase_left == 0) begin
          mode = stall_mode_t'($urandom_range(0, 3));
          phase_left = $urandom_range(50, 400);
          mask = 8'($urandom);
        end
        phase_left--;
        case (mode)
          STALL_NONE: out_stall <= 1'b0;
          STALL_HALF: out_stall <= ($urandom_range(0, 1) == 1);
          STALL_MOST: out_stall <= ($urandom_range(0, 3) != 0);
          default: begin
            out_stall <= mask[0];
            mask = {mask[0], mask[7:1]};
          end
        endcase
      end
    end
  end

  function automatic logic signed [COORD_BITS-1:0] pick_coord(coord_mode_t mode, int center,
                                                              int spread);
    case (mode)
      COORD_EXTREME: begin
        case ($urandom_range(0, 4))
          0: return COORD_MIN;
          1: return COORD_MAX;
          2: return '0;
          3: return '1;
          default: return 1;
        endcase
      end
      COORD_CLUSTER: return COORD_BITS'(center + $urandom_range(0, 2 * spread) - spread);
      default: return COORD_BITS'($urandom);
    endcase
  endfunction

  // one point word; the sender idles between bursts, never in reaction to stall
  task automatic send_point(input logic signed [COORD_BITS-1:0] x,
                            input logic signed [COORD_BITS-1:0] y, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = quiet_sender ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid <= 1'b1;
    point_x <= x;
    point_y <= y;
    last_point <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    points_sent++;
  endtask

  task automatic send_set(int len, coord_mode_t mode);
    int center_x, center_y, spread, i;
    center_x = $urandom;
    center_y = $urandom;
    spread = 1 << $urandom_range(0, 14);
    quiet_sender = ($urandom_range(0, 3) == 0);
    for (i = 0; i < len; i++) begin
      send_point(pick_coord(mode, center_x, spread), pick_coord(mode, center_y, spread),
                 i == len - 1);
    end
  endtask

  initial begin
    int len;
    rst = 1'b1;
    in_valid = 1'b0;
    point_x = '0;
    point_y = '0;
    last_point = 1'b0;
    burst_left = 0;
    points_sent = 0;
    hold_req = 1'b0;
    quiet_sender = 1'b0;
    pressure_done = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // single points: zero deviation
    send_point(0, 0, 1'b1);
    send_point(COORD_MIN, COORD_MAX, 1'b1);
    // widest spread along both diagonals
    send_point(COORD_MIN, COORD_MIN, 1'b0);
    send_point(COORD_MAX, COORD_MAX, 1'b1);
    send_point(COORD_MAX, COORD_MIN, 1'b0);
    send_point(COORD_MIN, COORD_MAX, 1'b1);
    // identical points
    send_point(12345, -12345, 1'b0);
    send_point(12345, -12345, 1'b0);
    send_point(12345, -12345, 1'b1);
    // unit circle: exactly 1.0
    send_point(1, 0, 1'b0);
    send_point(-1, 0, 1'b0);
    send_point(0, 1, 1'b0);
    send_point(0, -1, 1'b1);
    // half a unit: fraction bits only
    send_point(0, 0, 1'b0);
    send_point(1, 0, 1'b1);
    send_set(6, COORD_EXTREME);

    while (points_sent < ITEM_TARGET) begin
      if (!pressure_done && points_sent >= ITEM_TARGET / 2) begin
        // receiver holds off while short sets keep coming: queue fills, input stalls
        hold_req = 1'b1;
        pressure_done = 1'b1;
        repeat (40) send_set($urandom_range(1, 2), COORD_ANY);
      end else begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
        send_set(len, coord_mode_t'($urandom_range(0, 2)));
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (results_waiting != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && results_waiting == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

[filelist.f]
design/rrd_pkg.sv
design/rrd_front.sv
design/rrd_job_queue.sv
design/rrd_back.sv
design/radial_rms_deviation.sv
bench/rrd_checker.sv
bench/testbench.sv
